[rtl/ihv_pkg.sv]
// ----------------------------------------------------------------------------
// ihv_pkg
// Shared types, constants and helpers of the installer header validator:
// header layout, verdict status codes and the packing of the result item.
// ----------------------------------------------------------------------------
`default_nettype none

package ihv_pkg;

  // Header layout and limits.
  localparam int unsigned HEADER_BYTES   = 56;
  localparam int unsigned NAME_LIMIT_DEF = 260;
  localparam int unsigned HDR_CNT_W      = $clog2(HEADER_BYTES);
  localparam int unsigned NUM_WORDS      = 6;
  localparam logic [15:0] MAGIC_VALUE    = 16'hECDB;
  localparam logic [31:0] SIZE_CAP       = 32'h4000_0000;
  localparam logic [7:0]  CHAR_LOW       = 8'h20;
  localparam logic [7:0]  CHAR_HIGH      = 8'h7E;

  // Port widths.
  localparam int unsigned SPAN_W     = 40;
  localparam int unsigned STATUS_W   = 4;
  localparam int unsigned SIZE_W     = 31;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned CSIZE_W    = 32;
  localparam int unsigned NAME_LEN_W = 9;

  // Result item packing, lowest field first.
  localparam int unsigned OFS_STATUS = 0;
  localparam int unsigned OFS_METHOD = OFS_STATUS + STATUS_W;
  localparam int unsigned OFS_PLAIN  = OFS_METHOD + 1;
  localparam int unsigned OFS_PACKED = OFS_PLAIN + SIZE_W;
  localparam int unsigned OFS_OFFSET = OFS_PACKED + SIZE_W;
  localparam int unsigned OFS_TIME   = OFS_OFFSET + SIZE_W;
  localparam int unsigned OFS_CSIZE  = OFS_TIME + TIME_W;
  localparam int unsigned OFS_NLEN   = OFS_CSIZE + CSIZE_W;
  localparam int unsigned RES_BITS   = OFS_NLEN + NAME_LEN_W;
  localparam int unsigned M_TDATA_W  = ((RES_BITS + 7) / 8) * 8;

  // Header word slots: time, plain size, packed size, offset, inverse, repeat.
  localparam int unsigned W_TIME   = 0;
  localparam int unsigned W_PLAIN  = 1;
  localparam int unsigned W_PACKED = 2;
  localparam int unsigned W_OFFSET = 3;
  localparam int unsigned W_INV    = 4;
  localparam int unsigned W_REPEAT = 5;

  typedef logic [HDR_CNT_W-1:0] hdr_cnt_t;
  typedef hdr_cnt_t word_at_t [NUM_WORDS];
  localparam word_at_t WORD_AT = '{6'h14, 6'h1C, 6'h24, 6'h2C, 6'h30, 6'h34};

  // Verdict status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 4'd0,
    ST_SHORT       = 4'd1,
    ST_MAGIC       = 4'd2,
    ST_NEG_SIZE    = 4'd3,
    ST_OFFSET      = 4'd4,
    ST_COMPLEMENT  = 4'd5,
    ST_MISMATCH    = 4'd6,
    ST_TOO_BIG     = 4'd7,
    ST_OFFSET_LOW  = 4'd8,
    ST_DATA_RANGE  = 4'd9,
    ST_NAME_RANGE  = 4'd10,
    ST_NO_NAME     = 4'd11,
    ST_BAD_CHAR    = 4'd12
  } status_e;

  // Captured header fields as seen by the header check.
  typedef struct packed {
    logic [15:0] magic;
    logic [31:0] plain;
    logic [31:0] packed_sz;
    logic [31:0] offs;
    logic [31:0] inv;
    logic [31:0] again;
  } hdr_t;

  // A name character is rejected when it is not printable or is reserved.
  function automatic logic char_bad(input logic [7:0] c);
    logic bad;
    bad = (c < CHAR_LOW) || (c > CHAR_HIGH);
    if (c inside {8'h22, 8'h2A, 8'h3C, 8'h3E, 8'h3F, 8'h7C, 8'h3A}) begin
      bad = 1'b1;
    end
    return bad;
  endfunction

endpackage

`default_nettype wire

[rtl/ihv_header_check.sv]
// ----------------------------------------------------------------------------
// ihv_header_check
// Judges a complete header in one pass: magic, sizes, offset and its
// complement, size cap and the fit of the data and name areas in the span.
// ----------------------------------------------------------------------------
`default_nettype none

module ihv_header_check #(
  parameter int unsigned NAME_LIMIT = ihv_pkg::NAME_LIMIT_DEF,
  parameter int unsigned ROOM_W     = $clog2(NAME_LIMIT + 2)
) (
  input  ihv_pkg::hdr_t                 hdr_i,
  input  logic [ihv_pkg::SPAN_W-1:0]    span_i,
  output ihv_pkg::status_e              status_o,
  output logic [ROOM_W-1:0]             room_o
);
  import ihv_pkg::*;

  localparam logic [31:0] OffsMin  = 32'(HEADER_BYTES + 1);
  localparam logic [31:0] RoomMax  = 32'(NAME_LIMIT + 1);
  localparam logic [31:0] OffsCap  = 32'(HEADER_BYTES + NAME_LIMIT + 1);

  logic [31:0]       room_full;
  logic [SPAN_W:0]   data_end;
  logic [SPAN_W:0]   name_end;
  logic [SPAN_W:0]   span_ext;

  // Areas are compared as end positions; offsets and sizes are below 2^31 here.
  assign span_ext  = {1'b0, span_i};
  assign data_end  = (SPAN_W + 1)'(hdr_i.offs) + (SPAN_W + 1)'(hdr_i.packed_sz);
  assign room_full = (hdr_i.offs > OffsCap) ? RoomMax : (hdr_i.offs - 32'(HEADER_BYTES));
  assign name_end  = (SPAN_W + 1)'(HEADER_BYTES) + (SPAN_W + 1)'(room_full);
  assign room_o    = ROOM_W'(room_full);

  // Checks in priority order; the first failure names the verdict.
  always_comb begin
    if (hdr_i.magic != MAGIC_VALUE) begin
      status_o = ST_MAGIC;
    end else if (hdr_i.plain[31] || hdr_i.packed_sz[31]) begin
      status_o = ST_NEG_SIZE;
    end else if ((hdr_i.offs == '0) || hdr_i.offs[31]) begin
      status_o = ST_OFFSET;
    end else if (hdr_i.offs != ~hdr_i.inv) begin
      status_o = ST_COMPLEMENT;
    end else if ((hdr_i.again == '0) || hdr_i.again[31] ||
                 (hdr_i.again != hdr_i.packed_sz)) begin
      status_o = ST_MISMATCH;
    end else if (hdr_i.plain > SIZE_CAP) begin
      status_o = ST_TOO_BIG;
    end else if (hdr_i.offs < OffsMin) begin
      status_o = ST_OFFSET_LOW;
    end else if (data_end > span_ext) begin
      status_o = ST_DATA_RANGE;
    end else if (name_end > span_ext) begin
      status_o = ST_NAME_RANGE;
    end else begin
      status_o = ST_OK;
    end
  end

endmodule

`default_nettype wire

[rtl/installer_header_validator_core.sv]
// ----------------------------------------------------------------------------
// installer_header_validator_core
// Streams the bytes of one installer container, checks its header and name
// and delivers one verdict item per container.
// ----------------------------------------------------------------------------
// The block takes one container byte per clock, with tuser marking byte 0 of
// a new container. Each byte passes an input register and is then handled
// there (header field capture, the full header check at the last header
// byte, or one name character check), so a new byte is accepted every
// cycle while the output side keeps up. A verdict item is formed from the
// byte that decides it in the input register and is held in an output
// register until it is taken; a stalled output holds back the input only
// once both registers are full. A container that is too short for its header
// gets its verdict from its first byte. Bytes that arrive after a verdict and
// before the next marked first byte are consumed and dropped. The span
// register is written through its own channel, which is always ready, and
// should be changed only while no container is being parsed.
`default_nettype none

module installer_header_validator_core #(
  parameter int unsigned NAME_LIMIT = ihv_pkg::NAME_LIMIT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration: available span in bytes.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ihv_pkg::SPAN_W-1:0]        cfg_data_i,
  // Input stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]                        s_axis_tuser,   // [0] first_byte
  // Verdict stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [3:0] status, [4] method, [35:5] plain_size, [66:36] packed_size,
  // [97:67] payload_offset, [129:98] file_time, [161:130] container_size,
  // [170:162] name_length, [175:171] zero
  output logic [ihv_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
  import ihv_pkg::*;

  localparam int unsigned RoomW = $clog2(NAME_LIMIT + 2);
  localparam logic [STATUS_W-1:0] ShortSpanLimit = '0;
  localparam logic [SPAN_W-1:0]   SpanMin = SPAN_W'(HEADER_BYTES + 2);
  localparam hdr_cnt_t            HdrLast = HDR_CNT_W'(HEADER_BYTES - 1);

  // Configuration register.
  logic [SPAN_W-1:0] span_q;

  // Input register.
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_first_q;

  // Parse state.
  logic             idle_q, idle_d;
  logic             in_name_q, in_name_d;
  hdr_cnt_t         hdr_cnt_q, hdr_cnt_d;
  logic [RoomW-1:0] name_pos_q, name_pos_d;
  logic [RoomW-1:0] room_q, room_d;
  logic             bad_q, bad_d;
  logic [15:0]      magic_q, magic_d;
  logic [31:0]      words_q [NUM_WORDS];
  logic [31:0]      words_d [NUM_WORDS];

  // Output register.
  logic                 out_vld_q, out_vld_d;
  logic [M_TDATA_W-1:0] out_data_q, out_data_d;

  logic             advance;
  logic             take;
  hdr_t             hdr;
  status_e          chk_status;
  logic [RoomW-1:0] chk_room;

  // Input register advances whenever the output register can take a result.
  assign advance       = !out_vld_q || m_axis_tready;
  assign take          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // Header words including the byte now being handled.
  assign hdr.magic     = magic_d;
  assign hdr.plain     = words_d[W_PLAIN];
  assign hdr.packed_sz = words_d[W_PACKED];
  assign hdr.offs      = words_d[W_OFFSET];
  assign hdr.inv       = words_d[W_INV];
  assign hdr.again     = words_d[W_REPEAT];

  ihv_header_check #(
    .NAME_LIMIT (NAME_LIMIT),
    .ROOM_W     (RoomW)
  ) u_check (
    .hdr_i    (hdr),
    .span_i   (span_q),
    .status_o (chk_status),
    .room_o   (chk_room)
  );

  // Per-byte parse step and verdict formation.
  always_comb begin
    logic             e_idle;
    logic             e_in_name;
    hdr_cnt_t         e_cnt;
    logic [RoomW-1:0] e_pos;
    logic             e_bad;
    logic             give;
    status_e          st;
    logic [NAME_LEN_W-1:0] nlen;
    logic [RoomW:0]   pos_next;
    logic [31:0]      plain_w;
    logic [31:0]      packed_w;
    logic [31:0]      offs_w;
    logic [31:0]      csize;

    idle_d     = idle_q;
    in_name_d  = in_name_q;
    hdr_cnt_d  = hdr_cnt_q;
    name_pos_d = name_pos_q;
    room_d     = room_q;
    bad_d      = bad_q;
    magic_d    = magic_q;
    words_d    = words_q;
    give       = 1'b0;
    st         = ST_OK;
    nlen       = '0;

    // A marked first byte restarts the parse.
    e_idle    = in_first_q ? 1'b0 : idle_q;
    e_in_name = in_first_q ? 1'b0 : in_name_q;
    e_cnt     = in_first_q ? '0 : hdr_cnt_q;
    e_pos     = in_first_q ? '0 : name_pos_q;
    e_bad     = in_first_q ? 1'b0 : bad_q;
    pos_next  = {1'b0, e_pos} + (RoomW + 1)'(1);

    // Header byte capture, landing in its word slot.
    if (!e_in_name) begin
      if (e_cnt == hdr_cnt_t'(0)) magic_d[7:0]  = in_byte_q;
      if (e_cnt == hdr_cnt_t'(1)) magic_d[15:8] = in_byte_q;
      for (int i = 0; i < NUM_WORDS; i++) begin
        for (int k = 0; k < 4; k++) begin
          if (e_cnt == WORD_AT[i] + HDR_CNT_W'(k)) words_d[i][8*k +: 8] = in_byte_q;
        end
      end
    end

    if (take) begin
      idle_d    = e_idle;
      in_name_d = e_in_name;
      hdr_cnt_d = e_cnt;
      name_pos_d = e_pos;
      bad_d     = e_bad;
      if (in_first_q && (span_q < SpanMin)) begin
        give   = 1'b1;
        st     = ST_SHORT;
        idle_d = 1'b1;
      end else if (e_idle) begin
        give = 1'b0;
      end else if (!e_in_name) begin
        hdr_cnt_d = e_cnt + hdr_cnt_t'(1);
        if (e_cnt == HdrLast) begin
          if (chk_status != ST_OK) begin
            give   = 1'b1;
            st     = chk_status;
            idle_d = 1'b1;
          end else begin
            in_name_d  = 1'b1;
            room_d     = chk_room;
            name_pos_d = '0;
          end
        end
      end else begin
        // Name character step.
        if (in_byte_q == 8'h00) begin
          give   = 1'b1;
          idle_d = 1'b1;
          if (e_pos == '0) begin
            st = ST_NO_NAME;
          end else begin
            st   = e_bad ? ST_BAD_CHAR : ST_OK;
            nlen = NAME_LEN_W'(e_pos);
          end
        end else begin
          if (char_bad(in_byte_q)) bad_d = 1'b1;
          if (pos_next >= {1'b0, room_q}) begin
            give   = 1'b1;
            st     = ST_NO_NAME;
            idle_d = 1'b1;
          end else begin
            name_pos_d = pos_next[RoomW-1:0];
          end
        end
      end
    end

    // Verdict payload; a failed verdict carries only its status.
    plain_w  = words_d[W_PLAIN];
    packed_w = words_d[W_PACKED];
    offs_w   = words_d[W_OFFSET];
    csize    = offs_w + packed_w;
    out_data_d = '0;
    out_data_d[OFS_STATUS +: STATUS_W] = st;
    if (st == ST_OK) begin
      out_data_d[OFS_METHOD]           = (plain_w != '0);
      out_data_d[OFS_PLAIN  +: SIZE_W] = (plain_w == '0) ? packed_w[SIZE_W-1:0]
                                                         : plain_w[SIZE_W-1:0];
      out_data_d[OFS_PACKED +: SIZE_W] = packed_w[SIZE_W-1:0];
      out_data_d[OFS_OFFSET +: SIZE_W] = offs_w[SIZE_W-1:0];
      out_data_d[OFS_TIME   +: TIME_W] = words_d[W_TIME];
      out_data_d[OFS_CSIZE  +: CSIZE_W] = csize;
      out_data_d[OFS_NLEN   +: NAME_LEN_W] = nlen;
    end
    out_data_d[OFS_STATUS +: STATUS_W] = out_data_d[OFS_STATUS +: STATUS_W] | ShortSpanLimit;

    // Output register is loaded with a verdict or drained when taken.
    if (give) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      span_q <= cfg_data_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser[0];
    end
  end

  // Parse control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q     <= 1'b1;
      in_name_q  <= 1'b0;
      hdr_cnt_q  <= '0;
      name_pos_q <= '0;
      room_q     <= '0;
      bad_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      idle_q     <= idle_d;
      in_name_q  <= in_name_d;
      hdr_cnt_q  <= hdr_cnt_d;
      name_pos_q <= name_pos_d;
      room_q     <= room_d;
      bad_q      <= bad_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Header captures; every byte is written before the header check reads it.
  always_ff @(posedge clk_i) begin
    if (take) begin
      magic_q <= magic_d;
      words_q <= words_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (take && out_vld_d && advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

[rtl/ihv_checker.sv]
// ----------------------------------------------------------------------------
// ihv_checker
// Port-level checks on the verdict stream of the installer header validator,
// bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ihv_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_o,
  input  logic [ihv_pkg::SPAN_W-1:0]        cfg_data_i,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,
  input  logic [0:0]                        s_axis_tuser,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [ihv_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
  import ihv_pkg::*;

  logic [STATUS_W-1:0] status;
  logic                method;
  logic [SIZE_W-1:0]   plain_size;
  logic [SIZE_W-1:0]   packed_size;
  logic [SIZE_W-1:0]   payload_offset;
  logic [CSIZE_W-1:0]  container_size;
  logic [NAME_LEN_W-1:0] name_length;
  logic                ok;

  assign status         = m_axis_tdata[OFS_STATUS +: STATUS_W];
  assign method         = m_axis_tdata[OFS_METHOD];
  assign plain_size     = m_axis_tdata[OFS_PLAIN +: SIZE_W];
  assign packed_size    = m_axis_tdata[OFS_PACKED +: SIZE_W];
  assign payload_offset = m_axis_tdata[OFS_OFFSET +: SIZE_W];
  assign container_size = m_axis_tdata[OFS_CSIZE +: CSIZE_W];
  assign name_length    = m_axis_tdata[OFS_NLEN +: NAME_LEN_W];
  assign ok             = m_axis_tvalid && (status == ST_OK);

  // A stalled verdict stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("verdict changed while stalled");

  // A failed verdict carries nothing but its status.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status != ST_OK) |-> m_axis_tdata[M_TDATA_W-1:STATUS_W] == '0)
    else $error("failed verdict carries field data");

  // A stored entry reports its packed size as its plain size.
  a_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ok && !method |-> plain_size == packed_size)
    else $error("stored entry sizes differ");

  // Container size is offset plus packed size.
  a_csize: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ok |-> container_size == (CSIZE_W'(payload_offset) + CSIZE_W'(packed_size)))
    else $error("container size inconsistent");

  // A good verdict has a name and an offset past the header.
  a_ok_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ok |-> (name_length != '0) && (payload_offset > SIZE_W'(HEADER_BYTES)))
    else $error("good verdict with empty name or low offset");

endmodule

bind installer_header_validator_core ihv_checker u_ihv_checker (.*);

`default_nettype wire
